>>> rtl/core/srs_pkg.sv
package srs_pkg;

    localparam int COUNT_BITS_DEF = 20;
    localparam logic [47:0] DEFAULT_NAV_RST = 48'd65536;
    localparam logic [31:0] CHANGE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE_Q28 = 32'h1000_0000;
    localparam logic [63:0] VAR_MAX = 64'h0000_000F_FFFF_FFFF;

    localparam logic [3:0] K_DAYS = 4'd0;
    localparam logic [3:0] K_BEGIN_NAV = 4'd1;
    localparam logic [3:0] K_END_NAV = 4'd2;
    localparam logic [3:0] K_BEGIN_TOT = 4'd3;
    localparam logic [3:0] K_END_TOT = 4'd4;
    localparam logic [3:0] K_MAX_CHG = 4'd5;
    localparam logic [3:0] K_MIN_CHG = 4'd6;
    localparam logic [3:0] K_MAX_NAV = 4'd7;
    localparam logic [3:0] K_MIN_NAV = 4'd8;
    localparam logic [3:0] K_MAX_TOT = 4'd9;
    localparam logic [3:0] K_MIN_TOT = 4'd10;
    localparam logic [3:0] K_STD_DEV = 4'd11;

    typedef struct packed {
        logic [19:0] day;
        logic [47:0] nav;
        logic [47:0] total_value;
        logic        first;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         stat_kind;
        logic signed [63:0] stat_value;
        logic [19:0]        stat_day;
        logic               last_of_run;
    } t_out_item;

endpackage

>>> rtl/core/series_return_statistics.sv
// Series return statistics. Items are samples (day, nav, total value); the item
// marked first is the baseline, every later one adds a change nav/prev-1 to a
// running mean and M2 and to the extremes. One shared restoring divider, a
// shift-add multiplier and a digit-by-digit square root do the arithmetic, so
// o_stall stays high while an item is worked on: a later item runs 32 ratio steps,
// 41 mean-division steps and 41 multiply steps, and an item marked last may add
// 64 divide steps and 32 root steps for the standard deviation before twelve
// result items go out, one per cycle unless i_stall holds them.
// i_cfg_data is default_nav.
module series_return_statistics #(
    parameter int COUNT_BITS = srs_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [47:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  srs_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output srs_pkg::t_out_item  o_item
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CDIV = 3'd1;
    localparam logic [2:0] S_POST = 3'd2;
    localparam logic [2:0] S_MDIV = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_VDIV = 3'd5;
    localparam logic [2:0] S_SQRT = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [2:0]  r_state;
    logic [6:0]  r_cnt;
    logic [47:0] r_dflt;
    srs_pkg::t_in_item r_item;
    logic [47:0] r_prev;
    logic signed [39:0] r_mean;
    logic [63:0] r_m2;
    logic [COUNT_BITS-1:0] r_count;
    logic [47:0] r_bnav, r_enav, r_btot, r_etot;
    logic signed [31:0] r_cmax, r_cmin, r_change;
    logic [47:0] r_nmax, r_nmin, r_tmax, r_tmin;
    logic [19:0] r_d_cmax, r_d_cmin, r_d_nmax, r_d_nmin, r_d_tmax, r_d_tmin;
    logic signed [40:0] r_dold;
    logic [48:0] r_rem;
    logic [63:0] r_quo;
    logic [47:0] r_dvs;
    logic [79:0] r_ma, r_acc;
    logic [40:0] r_mb;
    logic [34:0] r_srem;
    logic [31:0] r_root;
    logic [31:0] r_sd;
    logic [3:0]  r_kind;

    // shared divider step
    logic [49:0] div_sh;
    logic        div_ge;
    logic [49:0] div_sub;
    assign div_sh  = {r_rem, r_quo[63]};
    assign div_ge  = div_sh >= {2'b00, r_dvs};
    assign div_sub = div_sh - {2'b00, r_dvs};

    // square root step
    logic [34:0] sq_sh, sq_trial;
    logic        sq_ge;
    assign sq_sh    = {r_srem[32:0], r_quo[63:62]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    logic [51:0] prev9;
    logic        sat;
    assign prev9 = {1'b0, r_prev, 3'b000} + {4'b0000, r_prev};
    assign sat   = (r_prev == 48'd0) || ({4'b0000, i_item.nav} >= prev9);

    logic accept;
    assign accept = i_valid && (r_state == S_IDLE);

    // mean and deviation arithmetic
    logic signed [40:0] chg41, mean41, step41, dnew;
    logic signed [39:0] new_mean;
    logic [40:0] dold_mag, dnew_mag, qmag;
    logic [COUNT_BITS-1:0] n_count;
    logic first_change;
    assign chg41    = {{9{r_change[31]}}, r_change};
    assign mean41   = {r_mean[39], r_mean};
    assign dold_mag = r_dold[40] ? 41'(-r_dold) : 41'(r_dold);
    assign qmag     = r_quo[40:0];
    assign step41   = r_dold[40] ? -$signed(qmag) : $signed(qmag);
    assign new_mean = r_mean + step41[39:0];
    assign dnew     = chg41 - {new_mean[39], new_mean};
    assign dnew_mag = dnew[40] ? 41'(-dnew) : 41'(dnew);
    assign n_count  = (r_count != CNT_MAX) ? r_count + 1'b1 : r_count;
    assign first_change = (r_count == '0);

    logic [64:0] m2_sum;
    assign m2_sum = {1'b0, r_m2} + {13'd0, r_acc[79:28]};

    logic [63:0] var_sat;
    assign var_sat = (r_quo > srs_pkg::VAR_MAX) ? srs_pkg::VAR_MAX : r_quo;

    logic [COUNT_BITS-1:0] cnt_m1;
    assign cnt_m1 = r_count - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dflt   <= srs_pkg::DEFAULT_NAV_RST;
            r_prev   <= '0;
            r_mean   <= '0;
            r_m2     <= '0;
            r_count  <= '0;
            r_bnav   <= '0;
            r_enav   <= '0;
            r_btot   <= '0;
            r_etot   <= '0;
            r_cmax   <= '0;
            r_cmin   <= '0;
            r_nmax   <= '0;
            r_nmin   <= '0;
            r_tmax   <= '0;
            r_tmin   <= '0;
            r_d_cmax <= '0;
            r_d_cmin <= '0;
            r_d_nmax <= '0;
            r_d_nmin <= '0;
            r_d_tmax <= '0;
            r_d_tmin <= '0;
            r_kind   <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dflt <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item <= i_item;
                        r_kind <= srs_pkg::K_DAYS;
                        r_sd   <= '0;
                        if (i_item.first) begin
                            r_prev   <= i_item.nav;
                            r_mean   <= '0;
                            r_m2     <= '0;
                            r_count  <= '0;
                            r_bnav   <= i_item.nav;
                            r_enav   <= i_item.nav;
                            r_btot   <= i_item.total_value;
                            r_etot   <= i_item.total_value;
                            r_cmax   <= '0;
                            r_cmin   <= '0;
                            r_nmax   <= i_item.nav;
                            r_nmin   <= i_item.nav;
                            r_tmax   <= i_item.total_value;
                            r_tmin   <= i_item.total_value;
                            r_d_cmax <= '0;
                            r_d_cmin <= '0;
                            r_d_nmax <= i_item.day;
                            r_d_nmin <= i_item.day;
                            r_d_tmax <= i_item.day;
                            r_d_tmin <= i_item.day;
                            r_state  <= i_item.last ? S_EMIT : S_IDLE;
                        end else if (sat) begin
                            r_change <= srs_pkg::CHANGE_MAX;
                            r_state  <= S_POST;
                        end else begin
                            // quotient fits 32 bits, so the top dividend bits start as remainder
                            r_rem   <= {5'd0, i_item.nav[47:4]};
                            r_quo   <= {i_item.nav[3:0], 60'd0};
                            r_dvs   <= r_prev;
                            r_cnt   <= 7'd32;
                            r_state <= S_CDIV;
                        end
                    end
                end
                S_CDIV: begin
                    r_rem <= div_ge ? div_sub[48:0] : div_sh[48:0];
                    r_quo <= {r_quo[62:0], div_ge};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_change <= {r_quo[30:0], div_ge} - srs_pkg::ONE_Q28;
                        r_state  <= S_POST;
                    end
                end
                S_POST: begin
                    r_count <= n_count;
                    if (r_item.total_value > r_tmax) begin
                        r_tmax <= r_item.total_value;
                        r_d_tmax <= r_item.day;
                    end
                    if (r_item.total_value < r_tmin) begin
                        r_tmin <= r_item.total_value;
                        r_d_tmin <= r_item.day;
                    end
                    if (first_change || r_change > r_cmax) begin
                        r_cmax <= r_change;
                        r_d_cmax <= r_item.day;
                    end
                    if (first_change || r_change < r_cmin) begin
                        r_cmin <= r_change;
                        r_d_cmin <= r_item.day;
                    end
                    if (r_item.nav > r_nmax) begin
                        r_nmax <= r_item.nav;
                        r_d_nmax <= r_item.day;
                    end
                    if (r_item.nav < r_nmin) begin
                        r_nmin <= r_item.nav;
                        r_d_nmin <= r_item.day;
                    end
                    r_prev  <= r_item.nav;
                    r_enav  <= r_item.nav;
                    r_etot  <= r_item.total_value;
                    r_dold  <= chg41 - mean41;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_dvs   <= 48'(n_count);
                    r_cnt   <= 7'd42;
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    if (r_cnt == 7'd42) begin
                        // first cycle loads the magnitude, left aligned
                        r_quo <= {dold_mag, 23'd0};
                        r_cnt <= 7'd41;
                    end else begin
                        r_rem <= div_ge ? div_sub[48:0] : div_sh[48:0];
                        r_quo <= {r_quo[62:0], div_ge};
                        r_cnt <= r_cnt - 7'd1;
                    end
                    if (r_cnt == 7'd0) begin
                        r_mean  <= new_mean;
                        r_ma    <= {39'd0, dold_mag};
                        r_mb    <= dnew_mag;
                        r_acc   <= '0;
                        r_rem   <= r_rem;
                        r_quo   <= r_quo;
                        r_cnt   <= 7'd41;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma  <= {r_ma[78:0], 1'b0};
                    r_mb  <= {1'b0, r_mb[40:1]};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd0) begin
                        r_acc <= r_acc;
                        r_m2  <= m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];
                        if (!r_item.last) begin
                            r_state <= S_IDLE;
                        end else if (r_count >= COUNT_BITS'(2)) begin
                            r_rem   <= '0;
                            r_quo   <= m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];
                            r_dvs   <= 48'(cnt_m1);
                            r_cnt   <= 7'd64;
                            r_state <= S_VDIV;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_VDIV: begin
                    r_rem <= div_ge ? div_sub[48:0] : div_sh[48:0];
                    r_quo <= {r_quo[62:0], div_ge};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd0) begin
                        r_quo   <= {var_sat[35:0], 28'd0};
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_cnt   <= 7'd32;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_srem <= sq_ge ? sq_sh - sq_trial : sq_sh;
                    r_root <= {r_root[30:0], sq_ge};
                    r_quo  <= {r_quo[61:0], 2'b00};
                    r_cnt  <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_sd    <= {r_root[30:0], sq_ge};
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        r_kind <= r_kind + 4'd1;
                        if (r_kind == srs_pkg::K_STD_DEV) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);

    logic [63:0] v_out;
    logic [19:0] d_out;
    always_comb begin
        v_out = '0;
        d_out = '0;
        case (r_kind)
            srs_pkg::K_DAYS:      v_out = 64'(r_count);
            srs_pkg::K_BEGIN_NAV: v_out = {16'd0, (r_count == '0) ? r_dflt : r_bnav};
            srs_pkg::K_END_NAV:   v_out = {16'd0, (r_count == '0) ? r_dflt : r_enav};
            srs_pkg::K_BEGIN_TOT: v_out = {16'd0, r_btot};
            srs_pkg::K_END_TOT:   v_out = {16'd0, r_etot};
            srs_pkg::K_MAX_CHG: begin
                v_out = {{32{r_cmax[31]}}, r_cmax};
                d_out = r_d_cmax;
            end
            srs_pkg::K_MIN_CHG: begin
                v_out = {{32{r_cmin[31]}}, r_cmin};
                d_out = r_d_cmin;
            end
            srs_pkg::K_MAX_NAV: begin
                v_out = {16'd0, r_nmax};
                d_out = r_d_nmax;
            end
            srs_pkg::K_MIN_NAV: begin
                v_out = {16'd0, r_nmin};
                d_out = r_d_nmin;
            end
            srs_pkg::K_MAX_TOT: begin
                v_out = {16'd0, r_tmax};
                d_out = r_d_tmax;
            end
            srs_pkg::K_MIN_TOT: begin
                v_out = {16'd0, r_tmin};
                d_out = r_d_tmin;
            end
            srs_pkg::K_STD_DEV:   v_out = {32'd0, r_sd};
            default: begin
                v_out = '0;
                d_out = '0;
            end
        endcase
        // baseline-only series reports zeros apart from days and nav
        if (r_count == '0 && r_kind != srs_pkg::K_DAYS && r_kind != srs_pkg::K_BEGIN_NAV
                && r_kind != srs_pkg::K_END_NAV) begin
            v_out = '0;
            d_out = '0;
        end
    end

    assign o_item.stat_kind   = r_kind;
    assign o_item.stat_value  = $signed(v_out);
    assign o_item.stat_day    = d_out;
    assign o_item.last_of_run = (r_kind == srs_pkg::K_STD_DEV);

    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open during result run");

    a_kind_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_item.last_of_run) |=> (o_valid &&
        o_item.stat_kind == $past(o_item.stat_kind) + 4'd1))
        else $error("result kind did not advance");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_item.last_of_run) |=> !o_valid)
        else $error("result run did not end after std dev");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [47:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    srs_pkg::t_in_item   i_item = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    srs_pkg::t_out_item  o_item;

    localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] COUNT_TOP = (64'd1 << srs_pkg::COUNT_BITS_DEF) - 64'd1;

    series_return_statistics DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    class stats_scoreboard;
        logic [63:0] default_nav = 64'd65536;
        logic [63:0] prev_nav, m2, n_chg;
        logic signed [63:0] mean;
        logic [63:0] ends [4];
        logic signed [63:0] chg_hi, chg_lo;
        logic [63:0] val_ext [4];
        logic [19:0] ext_day [6];
        srs_pkg::t_out_item pending[$];
        int errors = 0;
        int runs = 0;

        function void clear();
            prev_nav = 0; m2 = 0; n_chg = 0; mean = 0;
            chg_hi = 0; chg_lo = 0;
            for (int i = 0; i < 4; i++) begin ends[i] = 0; val_ext[i] = 0; end
            for (int i = 0; i < 6; i++) ext_day[i] = 0;
        endfunction

        function logic signed [63:0] ratio(logic [63:0] nv, logic [63:0] pv);
            logic [127:0] q;
            if (pv == 0 || {64'd0, nv} >= 128'd9 * pv) return 64'sh7FFF_FFFF;
            q = ({64'd0, nv} << 28) / pv;
            return $signed(q[63:0]) - 64'sh1000_0000;
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void push(logic [3:0] k, logic [63:0] v, logic [19:0] d);
            srs_pkg::t_out_item o;
            o.stat_kind = k;
            o.stat_value = v;
            o.stat_day = d;
            o.last_of_run = (k == srs_pkg::K_STD_DEV);
            pending.push_back(o);
        endfunction

        function void note_sample(srs_pkg::t_in_item it);
            logic [63:0] nv, tv, var_q, sd, a_old, a_new, step;
            logic signed [63:0] chg, d_old, d_new, nm;
            logic [127:0] prod;
            logic first_chg;
            nv = {16'd0, it.nav};
            tv = {16'd0, it.total_value};
            if (it.first) begin
                clear();
                prev_nav = nv;
                ends[0] = nv; ends[1] = nv; ends[2] = tv; ends[3] = tv;
                val_ext[0] = nv; val_ext[1] = nv; val_ext[2] = tv; val_ext[3] = tv;
                for (int i = 2; i < 6; i++) ext_day[i] = it.day;
            end else begin
                chg = ratio(nv, prev_nav);
                first_chg = (n_chg == 0);
                if (n_chg < COUNT_TOP) n_chg++;
                if (tv > val_ext[2]) begin val_ext[2] = tv; ext_day[4] = it.day; end
                if (tv < val_ext[3]) begin val_ext[3] = tv; ext_day[5] = it.day; end
                if (first_chg || chg > chg_hi) begin chg_hi = chg; ext_day[0] = it.day; end
                if (first_chg || chg < chg_lo) begin chg_lo = chg; ext_day[1] = it.day; end
                if (nv > val_ext[0]) begin val_ext[0] = nv; ext_day[2] = it.day; end
                if (nv < val_ext[1]) begin val_ext[1] = nv; ext_day[3] = it.day; end
                d_old = chg - mean;
                a_old = d_old < 0 ? -d_old : d_old;
                step = a_old / n_chg;
                nm = d_old < 0 ? mean - $signed(step) : mean + $signed(step);
                d_new = chg - nm;
                a_new = d_new < 0 ? -d_new : d_new;
                prod = ({64'd0, a_old} * {64'd0, a_new}) >> 28;
                if (prod[127:64] != 0 || m2 > ~64'd0 - prod[63:0]) m2 = ~64'd0;
                else m2 = m2 + prod[63:0];
                mean = nm;
                prev_nav = nv;
                ends[1] = nv;
                ends[3] = tv;
            end
            if (!it.last) return;
            runs++;
            push(srs_pkg::K_DAYS, n_chg, 0);
            if (n_chg == 0) begin
                push(srs_pkg::K_BEGIN_NAV, default_nav, 0);
                push(srs_pkg::K_END_NAV, default_nav, 0);
                for (int k = srs_pkg::K_BEGIN_TOT; k <= srs_pkg::K_STD_DEV; k++)
                    push(k[3:0], 0, 0);
                return;
            end
            push(srs_pkg::K_BEGIN_NAV, ends[0], 0);
            push(srs_pkg::K_END_NAV, ends[1], 0);
            push(srs_pkg::K_BEGIN_TOT, ends[2], 0);
            push(srs_pkg::K_END_TOT, ends[3], 0);
            push(srs_pkg::K_MAX_CHG, chg_hi, ext_day[0]);
            push(srs_pkg::K_MIN_CHG, chg_lo, ext_day[1]);
            push(srs_pkg::K_MAX_NAV, val_ext[0], ext_day[2]);
            push(srs_pkg::K_MIN_NAV, val_ext[1], ext_day[3]);
            push(srs_pkg::K_MAX_TOT, val_ext[2], ext_day[4]);
            push(srs_pkg::K_MIN_TOT, val_ext[3], ext_day[5]);
            sd = 0;
            if (n_chg >= 2) begin
                var_q = m2 / (n_chg - 1);
                if (var_q > srs_pkg::VAR_MAX) var_q = srs_pkg::VAR_MAX;
                sd = root(var_q << 28);
            end
            push(srs_pkg::K_STD_DEV, sd, 0);
        endfunction

        function void check_stat(srs_pkg::t_out_item got);
            srs_pkg::t_out_item w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected stat %h", $time, got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.stat_kind !== w.stat_kind || got.stat_value !== w.stat_value ||
                got.stat_day !== w.stat_day || got.last_of_run !== w.last_of_run) begin
                $display("%0t: expected kind %0d value %h day %0d last %b,",
                    $time, w.stat_kind, w.stat_value, w.stat_day, w.last_of_run);
                $display("%0t:      got kind %0d value %h day %0d last %b",
                    $time, got.stat_kind, got.stat_value, got.stat_day, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    stats_scoreboard sb = new();
    int hold_off = 0;
    int sent = 0;
    logic [19:0] day_ctr = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_sample(i_item);
        if (i_rst_n && o_valid && !i_stall) sb.check_stat(o_item);
    end

    // receiver stalls at random, or for a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            i_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic logic [47:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 48'd0;
            1: return M48[47:0];
            2: return 48'({$urandom, $urandom});
            default: return 48'h1_0000 + 48'($urandom_range(0, 32'h4000)) - 48'h2000;
        endcase
    endfunction

    function automatic srs_pkg::t_in_item mk(logic [47:0] nv, logic [47:0] tv, bit f, bit l);
        srs_pkg::t_in_item it;
        day_ctr = day_ctr + 20'($urandom_range(1, 3));
        it.day = day_ctr;
        it.nav = nv;
        it.total_value = tv;
        it.first = f;
        it.last = l;
        return it;
    endfunction

    task automatic send(srs_pkg::t_in_item it);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_default(logic [47:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.default_nav = {16'd0, v};
    endtask

    task automatic random_series(int len);
        logic [47:0] nv, base;
        base = rand_val();
        send(mk(base, rand_val(), 1'b1, len == 1));
        nv = base;
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) nv = rand_val();
            else nv = nv + 48'($urandom_range(0, 4000)) - 48'd2000;
            send(mk(nv, rand_val(), 1'b0, i == len - 1));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // before any baseline: previous nav zero saturates the change
        send(mk(48'h1_0000, 48'h5_0000, 1'b0, 1'b1));
        send(mk(48'h2_0000, 48'h5_0000, 1'b1, 1'b1));
        send(mk(48'h0, 48'h0, 1'b1, 1'b0));
        send(mk(48'h1_0000, M48[47:0], 1'b0, 1'b0));
        send(mk(48'h9_0000, 48'h1, 1'b0, 1'b0));
        send(mk(48'h8_FFFF, 48'h1, 1'b0, 1'b0));
        send(mk(48'h0, 48'h0, 1'b0, 1'b1));
        send(mk(48'h1_0000, 48'h2, 1'b0, 1'b1));
        send(mk(M48[47:0], M48[47:0], 1'b1, 1'b0));
        send(mk(M48[47:0], 48'h0, 1'b0, 1'b1));
        send(mk(48'h1, 48'h7, 1'b1, 1'b0));
        send(mk(48'h1, 48'h7, 1'b0, 1'b0));
        send(mk(48'h0, 48'h7, 1'b0, 1'b1));
        drain();
        set_default(48'h0);
        send(mk(48'h3_0000, 48'h3, 1'b1, 1'b1));
        drain();
        set_default(M48[47:0]);
        send(mk(48'h3_0000, 48'h3, 1'b1, 1'b1));
        drain();

        // receiver holds off long while samples keep coming
        hold_off <= 400;
        random_series(2);
        random_series(6);
        random_series(3);
        drain();

        while (sent < 480) begin
            if ($urandom_range(0, 40) == 0) begin
                drain();
                set_default(rand_val());
            end
            if ($urandom_range(0, 9) == 0)
                send(mk(rand_val(), rand_val(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1))));
            else
                random_series($urandom_range(1, 12));
        end
        drain();

        $display("sent %0d samples, %0d statistics runs checked, random default nav",
            sent, sb.runs);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
